// File: design/spin_trial_move_generator_macros.svh
// Assertion helpers used by the checker file stmg_checker.sv.
`ifndef SPIN_TRIAL_MOVE_GENERATOR_MACROS_SVH
`define SPIN_TRIAL_MOVE_GENERATOR_MACROS_SVH

// Checked only while out of reset.
`define STMG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define STMG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/stmg_pkg.sv
package stmg_pkg;

  typedef enum logic [1:0] {
    KIND_FLIP    = 2'd0,
    KIND_UNIFORM = 2'd1,
    KIND_CONE    = 2'd2
  } kind_t;

  localparam logic [2:0] MODE_ADAPTIVE = 3'd0;
  localparam logic [2:0] MODE_FLIP     = 3'd1;
  localparam logic [2:0] MODE_UNIFORM  = 3'd2;
  localparam logic [2:0] MODE_FIXED    = 3'd3;
  localparam logic [2:0] MODE_COMBINED = 3'd4;

  localparam logic [1:0] REG_MOVE_MODE      = 2'd0;
  localparam logic [1:0] REG_CONE_WIDTH     = 2'd1;
  localparam logic [1:0] REG_ADAPTIVE_WIDTH = 2'd2;

  localparam logic [15:0] WIDTH_RESET = 16'd4096;

  // Fraction bits of the working vector and of the normalized magnitudes.
  localparam int WORK_FRAC = 30;
  // Working vector width: holds old spin plus sample times width, signed.
  localparam int VEC_W     = 40;

endpackage

// File: design/spin_trial_move_generator.sv
// Channel  Direction  Handshake           Payload
// in       sink       in_valid/in_stall   old_x/y/z, gauss_a/b/c, uniform_draw
// out      source     out_valid/out_stall new_x/y/z, move_used, zero_length
// cfg      sink       cfg_we              cfg_index, cfg_data
// One item enters per cycle while no held result stalls the pipeline; the
// 31-step root pipeline and the SPIN_BITS-1 step divider lanes make up most of its depth.
// Reset is synchronous, clears the valid bits and loads the config registers' defaults.
// A stalled result freezes the whole pipeline; in_stall is raised then.
module spin_trial_move_generator #(
  parameter int SPIN_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SPIN_BITS-1:0] in_old_x,
  input  logic [SPIN_BITS-1:0] in_old_y,
  input  logic [SPIN_BITS-1:0] in_old_z,
  input  logic [15:0]          in_gauss_a,
  input  logic [15:0]          in_gauss_b,
  input  logic [15:0]          in_gauss_c,
  input  logic [15:0]          in_uniform_draw,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SPIN_BITS-1:0] out_new_x,
  output logic [SPIN_BITS-1:0] out_new_y,
  output logic [SPIN_BITS-1:0] out_new_z,
  output logic [1:0]           out_move_used,
  output logic                 out_zero_length,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);
  import stmg_pkg::*;

  localparam int SF = SPIN_BITS - 2;
  localparam int UP = WORK_FRAC - SF;
  localparam int MB = WORK_FRAC;
  localparam int SB = 2 * MB + 2;
  localparam int RS = MB + 1;
  localparam int RB = MB + 1;
  localparam int RW = RB + 3;
  localparam int DQ = SF + 1;
  localparam int DR = RB + 1;
  localparam int DW = MB + SF + 1;

  typedef struct packed {
    kind_t                       kind;
    logic                        zero;
    logic [2:0]                  neg;
    logic [2:0][SPIN_BITS-1:0]   flip;
  } side_t;

  logic        adv;
  logic [2:0]  mode_r;
  logic [15:0] cone_width_r;
  logic [15:0] adaptive_width_r;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r           <= MODE_ADAPTIVE;
      cone_width_r     <= WIDTH_RESET;
      adaptive_width_r <= WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MOVE_MODE:      mode_r           <= cfg_data[2:0];
        REG_CONE_WIDTH:     cone_width_r     <= cfg_data;
        REG_ADAPTIVE_WIDTH: adaptive_width_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage A: decode the move
  logic                      a_valid_r;
  kind_t                     a_kind_r, a_kind_nxt;
  logic [15:0]               a_w_r, a_w_nxt;
  logic [2:0][SPIN_BITS-1:0] a_old_r;
  logic [2:0][15:0]          a_g_r;
  logic [17:0]               pick3;

  assign pick3 = {2'b00, in_uniform_draw} + {1'b0, in_uniform_draw, 1'b0};

  always_comb begin
    a_kind_nxt = KIND_CONE;
    a_w_nxt    = adaptive_width_r;
    case (mode_r)
      MODE_FLIP:     a_kind_nxt = KIND_FLIP;
      MODE_UNIFORM:  a_kind_nxt = KIND_UNIFORM;
      MODE_FIXED:    a_w_nxt    = cone_width_r;
      MODE_COMBINED: begin
        a_kind_nxt = kind_t'(pick3[17:16]);
        a_w_nxt    = cone_width_r;
      end
      default: ;
    endcase
  end

  // Stage B: scale the samples by the width (uniform moves pass them unscaled)
  logic                      b_valid_r;
  kind_t                     b_kind_r;
  logic [2:0][SPIN_BITS-1:0] b_old_r;
  logic [2:0][32:0]          b_prod_r, b_prod_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (a_kind_r == KIND_UNIFORM) begin
        b_prod_nxt[i] = 33'($signed(a_g_r[i]));
      end else begin
        b_prod_nxt[i] = 33'($signed(a_g_r[i]) * $signed({1'b0, a_w_r}));
      end
    end
  end

  // Stage C: form the vector, prepare the flip
  logic                  c_valid_r;
  side_t                 c_side_r, c_side_nxt;
  logic [2:0][VEC_W-1:0] c_v_r, c_v_nxt;

  always_comb begin
    logic signed [VEC_W-1:0] os, ps;
    c_side_nxt      = '0;
    c_side_nxt.kind = b_kind_r;
    for (int i = 0; i < 3; i++) begin
      os = VEC_W'($signed(b_old_r[i]));
      ps = VEC_W'($signed(b_prod_r[i]));
      if (b_kind_r == KIND_UNIFORM) begin
        c_v_nxt[i] = ps;
      end else begin
        c_v_nxt[i] = (os <<< UP) + (ps <<< 6);
      end
      if (b_old_r[i] == {1'b1, {(SPIN_BITS-1){1'b0}}}) begin
        c_side_nxt.flip[i] = {1'b0, {(SPIN_BITS-1){1'b1}}};
      end else begin
        c_side_nxt.flip[i] = SPIN_BITS'(-b_old_r[i]);
      end
    end
  end

  // Stage D: split sign and magnitude
  logic                  d_valid_r;
  side_t                 d_side_r, d_side_nxt;
  logic [2:0][VEC_W-1:0] d_mag_r, d_mag_nxt;

  always_comb begin
    d_side_nxt = c_side_r;
    for (int i = 0; i < 3; i++) begin
      d_side_nxt.neg[i] = c_v_r[i][VEC_W-1];
      d_mag_nxt[i]      = c_v_r[i][VEC_W-1] ? VEC_W'(-c_v_r[i]) : c_v_r[i];
    end
  end

  // Stage E: find the leading one of the largest magnitude
  logic                  e_valid_r;
  side_t                 e_side_r, e_side_nxt;
  logic [2:0][VEC_W-1:0] e_mag_r;
  logic                  e_right_r, e_right_nxt;
  logic [5:0]            e_amt_r, e_amt_nxt;
  logic [VEC_W-1:0]      mag_or;
  logic [5:0]            lead;

  assign mag_or = d_mag_r[0] | d_mag_r[1] | d_mag_r[2];

  always_comb begin
    lead = '0;
    for (int i = 0; i < VEC_W; i++) begin
      if (mag_or[i]) lead = 6'(i);
    end
    e_right_nxt     = lead >= 6'(MB);
    e_amt_nxt       = e_right_nxt ? lead - 6'(MB - 1) : 6'(MB - 1) - lead;
    e_side_nxt      = d_side_r;
    e_side_nxt.zero = mag_or == '0;
  end

  // Stage F: bring the top magnitude into [2^29, 2^30)
  logic                  f_valid_r;
  side_t                 f_side_r;
  logic [2:0][MB-1:0]    f_m_r, f_m_nxt;

  always_comb begin
    logic [VEC_W-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      sh         = e_right_r ? (e_mag_r[i] >> e_amt_r) : (e_mag_r[i] << e_amt_r);
      f_m_nxt[i] = sh[MB-1:0];
    end
  end

  // Stage G: squares
  logic                  g_valid_r;
  side_t                 g_side_r;
  logic [2:0][MB-1:0]    g_m_r;
  logic [2:0][2*MB-1:0]  g_sq_r, g_sq_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) g_sq_nxt[i] = f_m_r[i] * f_m_r[i];
  end

  // Root pipeline: one result bit per stage, index 0 holds the sum
  logic               rt_valid_r [0:RS];
  side_t              rt_side_r  [0:RS];
  logic [2:0][MB-1:0] rt_m_r     [0:RS];
  logic [SB-1:0]      rt_s_r     [0:RS];
  logic [RW-1:0]      rt_rem_r   [0:RS];
  logic [RB-1:0]      rt_root_r  [0:RS];
  logic [SB-1:0]      rt_s_nxt   [1:RS];
  logic [RW-1:0]      rt_rem_nxt [1:RS];
  logic [RB-1:0]      rt_root_nxt[1:RS];
  logic [SB-1:0]      sum_sq;

  assign sum_sq = SB'(g_sq_r[0]) + SB'(g_sq_r[1]) + SB'(g_sq_r[2]);

  always_comb begin
    logic [RW-1:0] r_in, trial;
    for (int k = 1; k <= RS; k++) begin
      r_in          = {rt_rem_r[k-1][RW-3:0], rt_s_r[k-1][SB-1:SB-2]};
      trial         = RW'({rt_root_r[k-1], 2'b01});
      rt_s_nxt[k]   = rt_s_r[k-1] << 2;
      if (r_in >= trial) begin
        rt_rem_nxt[k]  = r_in - trial;
        rt_root_nxt[k] = {rt_root_r[k-1][RB-2:0], 1'b1};
      end else begin
        rt_rem_nxt[k]  = r_in;
        rt_root_nxt[k] = {rt_root_r[k-1][RB-2:0], 1'b0};
      end
    end
  end

  // Divider lanes: one quotient bit per stage, index 0 holds the rounded dividend
  logic               dv_valid_r [0:DQ];
  side_t              dv_side_r  [0:DQ];
  logic [RB-1:0]      dv_n_r     [0:DQ];
  logic [2:0][DR-1:0] dv_rem_r   [0:DQ];
  logic [2:0][DQ-1:0] dv_low_r   [0:DQ];
  logic [2:0][DQ-1:0] dv_q_r     [0:DQ];
  logic [2:0][DR-1:0] dv_rem_nxt [0:DQ];
  logic [2:0][DQ-1:0] dv_low_nxt [0:DQ];
  logic [2:0][DQ-1:0] dv_q_nxt   [0:DQ];

  always_comb begin
    logic [DW-1:0] dvd;
    logic [DR-1:0] r_in;
    for (int i = 0; i < 3; i++) begin
      dvd = DW'({rt_m_r[RS][i], {SF{1'b0}}}) + DW'(rt_root_r[RS] >> 1);
      dv_rem_nxt[0][i] = DR'(dvd[DW-1:DQ]);
      dv_low_nxt[0][i] = dvd[DQ-1:0];
      dv_q_nxt[0][i]   = '0;
    end
    for (int k = 1; k <= DQ; k++) begin
      for (int i = 0; i < 3; i++) begin
        r_in             = {dv_rem_r[k-1][i][DR-2:0], dv_low_r[k-1][i][DQ-1]};
        dv_low_nxt[k][i] = dv_low_r[k-1][i] << 1;
        if (r_in >= DR'(dv_n_r[k-1])) begin
          dv_rem_nxt[k][i] = r_in - DR'(dv_n_r[k-1]);
          dv_q_nxt[k][i]   = {dv_q_r[k-1][i][DQ-2:0], 1'b1};
        end else begin
          dv_rem_nxt[k][i] = r_in;
          dv_q_nxt[k][i]   = {dv_q_r[k-1][i][DQ-2:0], 1'b0};
        end
      end
    end
  end

  // Output register
  logic                      out_valid_r;
  logic [2:0][SPIN_BITS-1:0] out_res_r, out_res_nxt;
  kind_t                     out_kind_r;
  logic                      out_zero_r;

  always_comb begin
    logic [SPIN_BITS-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = SPIN_BITS'(dv_q_r[DQ][i]);
      if (dv_side_r[DQ].kind == KIND_FLIP) begin
        out_res_nxt[i] = dv_side_r[DQ].flip[i];
      end else if (dv_side_r[DQ].zero) begin
        out_res_nxt[i] = '0;
      end else begin
        out_res_nxt[i] = dv_side_r[DQ].neg[i] ? SPIN_BITS'(-q) : q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      f_valid_r   <= 1'b0;
      g_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= RS; k++) rt_valid_r[k] <= 1'b0;
      for (int k = 0; k <= DQ; k++) dv_valid_r[k] <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= in_valid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= c_valid_r;
      e_valid_r   <= d_valid_r;
      f_valid_r   <= e_valid_r;
      g_valid_r   <= f_valid_r;
      rt_valid_r[0] <= g_valid_r;
      for (int k = 1; k <= RS; k++) rt_valid_r[k] <= rt_valid_r[k-1];
      dv_valid_r[0] <= rt_valid_r[RS];
      for (int k = 1; k <= DQ; k++) dv_valid_r[k] <= dv_valid_r[k-1];
      out_valid_r <= dv_valid_r[DQ];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_kind_r <= a_kind_nxt;
      a_w_r    <= a_w_nxt;
      a_old_r  <= {in_old_z, in_old_y, in_old_x};
      a_g_r    <= {in_gauss_c, in_gauss_b, in_gauss_a};
      b_kind_r <= a_kind_r;
      b_old_r  <= a_old_r;
      b_prod_r <= b_prod_nxt;
      c_side_r <= c_side_nxt;
      c_v_r    <= c_v_nxt;
      d_side_r <= d_side_nxt;
      d_mag_r  <= d_mag_nxt;
      e_side_r  <= e_side_nxt;
      e_mag_r   <= d_mag_r;
      e_right_r <= e_right_nxt;
      e_amt_r   <= e_amt_nxt;
      f_side_r <= e_side_r;
      f_m_r    <= f_m_nxt;
      g_side_r <= f_side_r;
      g_m_r    <= f_m_r;
      g_sq_r   <= g_sq_nxt;
      rt_side_r[0] <= g_side_r;
      rt_m_r[0]    <= g_m_r;
      rt_s_r[0]    <= sum_sq;
      rt_rem_r[0]  <= '0;
      rt_root_r[0] <= '0;
      for (int k = 1; k <= RS; k++) begin
        rt_side_r[k] <= rt_side_r[k-1];
        rt_m_r[k]    <= rt_m_r[k-1];
        rt_s_r[k]    <= rt_s_nxt[k];
        rt_rem_r[k]  <= rt_rem_nxt[k];
        rt_root_r[k] <= rt_root_nxt[k];
      end
      dv_side_r[0] <= rt_side_r[RS];
      dv_n_r[0]    <= rt_root_r[RS];
      dv_rem_r[0]  <= dv_rem_nxt[0];
      dv_low_r[0]  <= dv_low_nxt[0];
      dv_q_r[0]    <= dv_q_nxt[0];
      for (int k = 1; k <= DQ; k++) begin
        dv_side_r[k] <= dv_side_r[k-1];
        dv_n_r[k]    <= dv_n_r[k-1];
        dv_rem_r[k]  <= dv_rem_nxt[k];
        dv_low_r[k]  <= dv_low_nxt[k];
        dv_q_r[k]    <= dv_q_nxt[k];
      end
      out_res_r  <= out_res_nxt;
      out_kind_r <= dv_side_r[DQ].kind;
      out_zero_r <= (dv_side_r[DQ].kind != KIND_FLIP) && dv_side_r[DQ].zero;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_new_x       = out_res_r[0];
  assign out_new_y       = out_res_r[1];
  assign out_new_z       = out_res_r[2];
  assign out_move_used   = out_kind_r;
  assign out_zero_length = out_zero_r;

endmodule

// File: design/stmg_checker.sv
`include "spin_trial_move_generator_macros.svh"

module stmg_checker #(
  parameter int SPIN_BITS = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic [SPIN_BITS-1:0] in_old_x,
  input logic [SPIN_BITS-1:0] in_old_y,
  input logic [SPIN_BITS-1:0] in_old_z,
  input logic [15:0]          in_gauss_a,
  input logic [15:0]          in_gauss_b,
  input logic [15:0]          in_gauss_c,
  input logic [15:0]          in_uniform_draw,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [SPIN_BITS-1:0] out_new_x,
  input logic [SPIN_BITS-1:0] out_new_y,
  input logic [SPIN_BITS-1:0] out_new_z,
  input logic [1:0]           out_move_used,
  input logic                 out_zero_length,
  input logic                 cfg_we,
  input logic [1:0]           cfg_index,
  input logic [15:0]          cfg_data
);
  import stmg_pkg::*;

  `STMG_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")

  `STMG_ASSERT(a_hold, (out_valid && out_stall) |=> (out_valid && $stable(out_new_x) && $stable(out_new_y) && $stable(out_new_z) && $stable(out_move_used)), "stalled result changed")

  `STMG_ASSERT(a_backpressure, in_stall == (out_valid && out_stall), "input stall not tied to a held result")

  `STMG_ASSERT(a_zero_out, (out_valid && out_zero_length) |-> (out_new_x == '0 && out_new_y == '0 && out_new_z == '0 && out_move_used != KIND_FLIP), "zero-length result not cleared")

  `STMG_ASSERT(a_move_code, out_valid |-> (out_move_used == KIND_FLIP || out_move_used == KIND_UNIFORM || out_move_used == KIND_CONE), "bad move code")

endmodule

bind spin_trial_move_generator stmg_checker #(.SPIN_BITS(SPIN_BITS)) u_stmg_checker (.*);
